[src/pixel_format_converter_assert.svh]
// Assertion macros for the pixel format converter.
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pixel_format_converter: check failed");
`define PFC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pixel_format_converter: check failed");
`else
`define PFC_ASSERT(label, clk, rst_n, prop)
`define PFC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[src/pfc_pkg.sv]
package pfc_pkg;

    typedef logic [7:0] pix_t;
    typedef logic [1:0] pos_t;
    typedef logic [2:0] fmt_t;
    typedef logic [2:0] mode_t;

    localparam fmt_t FMT_RGB  = 3'd0;
    localparam fmt_t FMT_BGR  = 3'd1;
    localparam fmt_t FMT_RGBA = 3'd2;
    localparam fmt_t FMT_BGRA = 3'd3;
    localparam fmt_t FMT_ARGB = 3'd4;
    localparam fmt_t FMT_GRAY = 3'd5;

    localparam logic [2:0] REG_SOURCE_FORMAT = 3'd0;
    localparam logic [2:0] REG_DEST_FORMAT   = 3'd1;
    localparam logic [2:0] REG_SCALE_Q16     = 3'd2;
    localparam logic [2:0] REG_OFFSET_Q16    = 3'd3;
    localparam logic [2:0] REG_CLAMP_ENABLE  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_UNSUP  = 2'd2;

    localparam mode_t MODE_COLOR = 3'd0;
    localparam mode_t MODE_MEAN  = 3'd1;
    localparam mode_t MODE_GRAY  = 3'd2;
    localparam mode_t MODE_REPL  = 3'd3;
    localparam mode_t MODE_BAD   = 3'd4;

    localparam int CHAN_W = 10;
    localparam int PROD_W = 43;
    localparam int NUM_W  = 44;

    localparam pix_t ALPHA_OPAQUE = 8'd255;

    function automatic pos_t pos_r(input fmt_t f);
        case (f)
            FMT_BGR, FMT_BGRA: pos_r = 2'd2;
            FMT_ARGB:          pos_r = 2'd1;
            default:           pos_r = 2'd0;
        endcase
    endfunction

    function automatic pos_t pos_g(input fmt_t f);
        case (f)
            FMT_ARGB: pos_g = 2'd2;
            default:  pos_g = 2'd1;
        endcase
    endfunction

    function automatic pos_t pos_b(input fmt_t f);
        case (f)
            FMT_BGR, FMT_BGRA: pos_b = 2'd0;
            FMT_ARGB:          pos_b = 2'd3;
            default:           pos_b = 2'd2;
        endcase
    endfunction

    function automatic pos_t pos_a(input fmt_t f);
        case (f)
            FMT_RGBA, FMT_BGRA: pos_a = 2'd3;
            default:            pos_a = 2'd0;
        endcase
    endfunction

    function automatic logic has_alpha(input fmt_t f);
        case (f)
            FMT_RGBA, FMT_BGRA, FMT_ARGB: has_alpha = 1'b1;
            default:                      has_alpha = 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] fmt_size(input fmt_t f);
        case (f)
            FMT_RGB, FMT_BGR:             fmt_size = 3'd3;
            FMT_RGBA, FMT_BGRA, FMT_ARGB: fmt_size = 3'd4;
            default:                      fmt_size = 3'd1;
        endcase
    endfunction

    function automatic mode_t decode_mode(input fmt_t sf, input fmt_t df);
        if (sf > FMT_GRAY || df > FMT_GRAY)
            decode_mode = MODE_BAD;
        else if (sf != FMT_GRAY && df != FMT_GRAY)
            decode_mode = MODE_COLOR;
        else if (df == FMT_GRAY && (sf == FMT_RGB || sf == FMT_BGR))
            decode_mode = MODE_MEAN;
        else if (sf == FMT_GRAY && df == FMT_GRAY)
            decode_mode = MODE_GRAY;
        else if (sf == FMT_GRAY && df == FMT_RGB)
            decode_mode = MODE_REPL;
        else
            decode_mode = MODE_BAD;
    endfunction

    // floor(x / 3) for x below 768
    function automatic pix_t div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        div3 = p[18:11];
    endfunction

endpackage

[src/pixel_format_converter.sv]
// Pixel format converter. Takes one pixel per clock on the s_ stream and presents the
// converted pixel on the m_ stream from the result register (the accepting edge loads the
// input register, later advancing edges load the product and result registers), with
// full throughput of one pixel per clock set by the three-stage pipeline that advances
// whenever the result register is empty or being taken. Each channel is scaled and offset
// in signed Q16.16 with one 10 x 32 bit multiplier per channel lane; rgb/bgr to gray sums
// the channels first and divides by three after the shift. Write the configuration
// registers only while no pixel is in flight; cfg_ready is always high and writes take
// effect next cycle.
`include "pixel_format_converter_assert.svh"

module pixel_format_converter
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_byte0, in_byte1, in_byte2, in_byte3
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_byte0..out_byte3, byte_count[2:0], status[1:0], pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic signed [NUM_W-1:0] NEG_LIM_CH  = -44'sd65536;
    localparam logic signed [NUM_W-1:0] NEG_LIM_AVG = -44'sd196608;
    localparam logic signed [NUM_W-1:0] POS_LIM_CH  = 44'sd16777216;
    localparam logic signed [NUM_W-1:0] POS_LIM_AVG = 44'sd50331648;

    fmt_t               src_fmt_reg;
    fmt_t               dst_fmt_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] offset_reg;
    logic               clamp_reg;

    logic               adv;
    mode_t              mode;

    logic               in_valid_reg;
    pix_t               in_byte_reg [4];

    logic               prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg  [4];
    logic signed [PROD_W-1:0] prod_next [4];
    logic [CHAN_W-1:0]  chan [4];

    logic               out_valid_reg;
    pix_t               out_byte_reg [4];
    logic [2:0]         count_reg;
    logic [1:0]         status_reg;
    pix_t               out_byte_next [4];
    logic [1:0]         status_next;

    logic signed [NUM_W-1:0] off_ch;
    logic signed [NUM_W-1:0] off_avg;
    logic signed [NUM_W-1:0] num [4];
    pix_t               val [4];
    logic               oor [4];

    assign mode      = decode_mode(src_fmt_reg, dst_fmt_reg);
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, status_reg, count_reg,
                        out_byte_reg[3], out_byte_reg[2], out_byte_reg[1], out_byte_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= FMT_RGB;
            dst_fmt_reg <= FMT_RGB;
            scale_reg   <= 32'sd65536;
            offset_reg  <= 32'sd0;
            clamp_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: src_fmt_reg <= cfg_data[2:0];
                REG_DEST_FORMAT:   dst_fmt_reg <= cfg_data[2:0];
                REG_SCALE_Q16:     scale_reg   <= cfg_data;
                REG_OFFSET_Q16:    offset_reg  <= cfg_data;
                REG_CLAMP_ENABLE:  clamp_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg   <= s_tvalid;
            prod_valid_reg <= in_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // Select channel lanes and multiply by the gain.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            chan[i] = '0;
        case (mode)
            MODE_COLOR:
            begin
                chan[0] = CHAN_W'(in_byte_reg[pos_r(src_fmt_reg)]);
                chan[1] = CHAN_W'(in_byte_reg[pos_g(src_fmt_reg)]);
                chan[2] = CHAN_W'(in_byte_reg[pos_b(src_fmt_reg)]);
                chan[3] = CHAN_W'(in_byte_reg[pos_a(src_fmt_reg)]);
            end
            MODE_MEAN:
                chan[0] = CHAN_W'(in_byte_reg[0]) + CHAN_W'(in_byte_reg[1])
                        + CHAN_W'(in_byte_reg[2]);
            MODE_GRAY, MODE_REPL:
                chan[0] = CHAN_W'(in_byte_reg[0]);
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
            prod_next[i] = $signed({{(PROD_W-CHAN_W){1'b0}}, chan[i]})
                         * $signed({{(PROD_W-32){scale_reg[31]}}, scale_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_byte_reg[0] <= s_tdata[7:0];
            in_byte_reg[1] <= s_tdata[15:8];
            in_byte_reg[2] <= s_tdata[23:16];
            in_byte_reg[3] <= s_tdata[31:24];
            for (int i = 0; i < 4; i++)
                prod_reg[i] <= prod_next[i];
        end
    end

    // Add offset, truncate toward zero, range check; the rgb/bgr gray sum is divided by three.
    always_comb
    begin
        off_ch  = {{(NUM_W-32){offset_reg[31]}}, offset_reg};
        off_avg = (off_ch <<< 1) + off_ch;
        for (int i = 0; i < 4; i++)
        begin
            if (i == 0 && mode == MODE_MEAN)
            begin
                num[i] = {prod_reg[i][PROD_W-1], prod_reg[i]} + off_avg;
                if (num[i] <= NEG_LIM_AVG)
                begin
                    oor[i] = 1'b1;
                    val[i] = 8'd0;
                end
                else if (num[i] >= POS_LIM_AVG)
                begin
                    oor[i] = 1'b1;
                    val[i] = 8'd255;
                end
                else
                begin
                    oor[i] = 1'b0;
                    val[i] = num[i][NUM_W-1] ? 8'd0 : div3(num[i][25:16]);
                end
            end
            else
            begin
                num[i] = {prod_reg[i][PROD_W-1], prod_reg[i]} + off_ch;
                if (num[i] <= NEG_LIM_CH)
                begin
                    oor[i] = 1'b1;
                    val[i] = 8'd0;
                end
                else if (num[i] >= POS_LIM_CH)
                begin
                    oor[i] = 1'b1;
                    val[i] = 8'd255;
                end
                else
                begin
                    oor[i] = 1'b0;
                    val[i] = num[i][NUM_W-1] ? 8'd0 : num[i][23:16];
                end
            end
        end
    end

    // Place channels in destination order and set the status, zeroing all bytes on error.
    always_comb
    begin
        logic err;
        err = 1'b0;
        status_next = ST_OK;
        for (int i = 0; i < 4; i++)
            out_byte_next[i] = 8'd0;
        case (mode)
            MODE_COLOR:
            begin
                out_byte_next[pos_r(dst_fmt_reg)] = val[0];
                out_byte_next[pos_g(dst_fmt_reg)] = val[1];
                out_byte_next[pos_b(dst_fmt_reg)] = val[2];
                err = oor[0] || oor[1] || oor[2];
                if (has_alpha(dst_fmt_reg))
                begin
                    if (has_alpha(src_fmt_reg))
                    begin
                        out_byte_next[pos_a(dst_fmt_reg)] = val[3];
                        err = err || oor[3];
                    end
                    else
                        out_byte_next[pos_a(dst_fmt_reg)] = ALPHA_OPAQUE;
                end
            end
            MODE_MEAN, MODE_GRAY:
            begin
                out_byte_next[0] = val[0];
                err = oor[0];
            end
            MODE_REPL:
            begin
                out_byte_next[0] = val[0];
                out_byte_next[1] = val[0];
                out_byte_next[2] = val[0];
                err = oor[0];
            end
            default:
                status_next = ST_UNSUP;
        endcase
        if (status_next == ST_OK && err && !clamp_reg)
            status_next = ST_RANGE;
        if (status_next != ST_OK)
        begin
            for (int i = 0; i < 4; i++)
                out_byte_next[i] = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                out_byte_reg[i] <= out_byte_next[i];
            count_reg  <= fmt_size(dst_fmt_reg);
            status_reg <= status_next;
        end
    end

    `PFC_ASSERT(a_err_zero_bytes, clk, rst_n,
        (out_valid_reg && status_reg != ST_OK) |-> (m_tdata[31:0] == 32'd0))
    `PFC_ASSERT(a_count_matches_dest, clk, rst_n,
        out_valid_reg |-> (count_reg == fmt_size(dst_fmt_reg)))
    `PFC_ASSERT(a_unsup_status, clk, rst_n,
        (out_valid_reg && mode == MODE_BAD) |-> (status_reg == ST_UNSUP))
    `PFC_ASSERT(a_pipe_advance, clk, rst_n,
        (prod_valid_reg && adv) |=> out_valid_reg)

endmodule
